### rtl/core/zcst_pkg.sv
`default_nettype none

package zcst_pkg;

  // Event kinds on the func field
  localparam logic [1:0] FUNC_BEFORE = 2'd0;
  localparam logic [1:0] FUNC_AFTER  = 2'd1;
  localparam logic [1:0] FUNC_IRQ    = 2'd2;
  localparam logic [1:0] FUNC_RSVD   = 2'd3;

  // Action codes reported with every result word
  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_PUSH      = 2'd1;
  localparam logic [1:0] ACT_POP       = 2'd2;
  localparam logic [1:0] ACT_PUSH_DROP = 2'd3;

  // Frame kinds
  localparam logic [1:0] KIND_CALL = 2'd0;
  localparam logic [1:0] KIND_RST  = 2'd1;
  localparam logic [1:0] KIND_INT  = 2'd2;

  // Opcode decode constants
  localparam logic [7:0] OP_CALL      = 8'hCD;
  localparam logic [7:0] OP_CALL_CC   = 8'hC4;
  localparam logic [7:0] OP_RST       = 8'hC7;
  localparam logic [7:0] OP_CC_MASK   = 8'hC7;
  localparam logic [7:0] OP_RST_VEC   = 8'h38;
  localparam logic [7:0] OP_RET       = 8'hC9;
  localparam logic [7:0] OP_RET_CC    = 8'hC0;
  localparam logic [7:0] OP_ED_PREFIX = 8'hED;
  localparam logic [7:0] OP_RETI_SFX  = 8'h4D;
  localparam logic [7:0] OP_RETN_SFX  = 8'h45;

  // Stack pointer step of a call or return
  localparam logic [16:0] SP_STEP = 17'd2;

  typedef struct packed {
    logic [15:0] caller;
    logic [15:0] target;
    logic [15:0] sp;
    logic [1:0]  kind;
  } frame_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_POP_CHK,
    S_TOP_RD,
    S_RESULT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_evt;
    logic exec;
    logic rd_top;
    logic pop_one;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_evt;
    logic pop_hit;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/zcst_ctrl.sv
`default_nettype none

module zcst_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  zcst_pkg::dp_status_t  st_i,
  output zcst_pkg::ctrl_cmd_t   cmd_o
);

  zcst_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= zcst_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      zcst_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_evt = 1'b1;
          state_d        = zcst_pkg::S_EXEC;
        end
      end
      zcst_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = st_i.pop_evt ? zcst_pkg::S_POP_RD : zcst_pkg::S_TOP_RD;
      end
      zcst_pkg::S_POP_RD: begin
        cmd_o.rd_top = 1'b1;
        state_d      = zcst_pkg::S_POP_CHK;
      end
      zcst_pkg::S_POP_CHK: begin
        // read data already holds the top frame when the pop stops
        if (st_i.pop_hit) begin
          cmd_o.pop_one = 1'b1;
          state_d       = zcst_pkg::S_POP_RD;
        end else begin
          state_d = zcst_pkg::S_RESULT;
        end
      end
      zcst_pkg::S_TOP_RD: begin
        cmd_o.rd_top = 1'b1;
        state_d      = zcst_pkg::S_RESULT;
      end
      zcst_pkg::S_RESULT: begin
        if (!st_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = zcst_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = zcst_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // An accepted word always goes straight to execution
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == zcst_pkg::S_EXEC))
    else $error("accepted word did not enter execution");

  // Pop check only ever follows a top read
  a_chk_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == zcst_pkg::S_POP_CHK) |-> ($past(state_q) == zcst_pkg::S_POP_RD))
    else $error("pop check without a preceding read");

  // A stalled result holds the controller
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == zcst_pkg::S_RESULT && st_i.out_busy) |=> (state_q == zcst_pkg::S_RESULT))
    else $error("result left while output busy");
`endif

endmodule

`default_nettype wire

### rtl/core/zcst_dpath.sv
`default_nettype none

module zcst_dpath #(
  parameter int unsigned STACK_DEPTH = 64,
  localparam int unsigned IdxW = $clog2(STACK_DEPTH),
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // configuration
  input  wire                   cfg_valid_i,
  input  wire                   cfg_trace_enable_i,
  // input word
  input  wire  [1:0]            func_i,
  input  wire  [15:0]           pc_value_i,
  input  wire  [15:0]           sp_value_i,
  input  wire  [7:0]            opcode_byte_i,
  input  wire  [7:0]            second_byte_i,
  input  wire  [7:0]            third_byte_i,
  input  wire  [15:0]           irq_target_i,
  // control
  input  zcst_pkg::ctrl_cmd_t   cmd_i,
  output zcst_pkg::dp_status_t  st_o,
  // result word
  input  wire                   out_ready_i,
  output logic                  out_valid_o,
  output logic [1:0]            action_o,
  output logic [CntW-1:0]       stack_depth_o,
  output logic [15:0]           top_caller_o,
  output logic [15:0]           top_target_o,
  output logic [15:0]           top_sp_o,
  output logic [1:0]            top_kind_o
);

  localparam int unsigned SumW = CntW + 1;

  // Event word held for the duration of one item
  logic [1:0]  evt_func_q;
  logic [15:0] evt_pc_q, evt_sp_q, evt_irq_q;
  logic [7:0]  evt_b1_q, evt_b2_q, evt_b3_q;

  // Instruction latch
  logic [15:0] lat_pc_q, lat_sp_q;
  logic [7:0]  lat_b1_q, lat_b2_q, lat_b3_q;
  logic        lat_vld_q;

  logic            trace_en_q;
  logic [IdxW-1:0] oldest_q;
  logic [CntW-1:0] count_q;
  logic [1:0]      act_q;
  logic            out_vld_q;

  zcst_pkg::frame_t frame_mem [STACK_DEPTH];
  zcst_pkg::frame_t rd_frame_q;
  zcst_pkg::frame_t wr_frame;

  logic            is_call, is_rst, is_ret, sp_fell, sp_rose;
  logic            after_ok, push_call, push_int, push, pop_evt, full;
  logic [SumW-1:0] sum_wr, sum_top;
  logic [IdxW-1:0] wr_idx, top_idx, oldest_inc;

  // Event capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_evt) begin
      evt_func_q <= func_i;
      evt_pc_q   <= pc_value_i;
      evt_sp_q   <= sp_value_i;
      evt_b1_q   <= opcode_byte_i;
      evt_b2_q   <= second_byte_i;
      evt_b3_q   <= third_byte_i;
      evt_irq_q  <= irq_target_i;
    end
  end

  // Opcode decode on the latched instruction
  always_comb begin
    is_call = (lat_b1_q == zcst_pkg::OP_CALL) ||
              ((lat_b1_q & zcst_pkg::OP_CC_MASK) == zcst_pkg::OP_CALL_CC);
    is_rst  = ((lat_b1_q & zcst_pkg::OP_CC_MASK) == zcst_pkg::OP_RST);
    is_ret  = (lat_b1_q == zcst_pkg::OP_RET) ||
              ((lat_b1_q & zcst_pkg::OP_CC_MASK) == zcst_pkg::OP_RET_CC) ||
              ((lat_b1_q == zcst_pkg::OP_ED_PREFIX) &&
               ((lat_b2_q == zcst_pkg::OP_RETI_SFX) ||
                (lat_b2_q == zcst_pkg::OP_RETN_SFX)));
  end

  // Sp compare without wrap, 17 bits wide
  assign sp_fell = ({1'b0, evt_sp_q} + zcst_pkg::SP_STEP) == {1'b0, lat_sp_q};
  assign sp_rose = {1'b0, evt_sp_q} == ({1'b0, lat_sp_q} + zcst_pkg::SP_STEP);

  assign after_ok  = trace_en_q && (evt_func_q == zcst_pkg::FUNC_AFTER) && lat_vld_q;
  assign push_call = after_ok && sp_fell && (is_call || is_rst);
  assign push_int  = trace_en_q && (evt_func_q == zcst_pkg::FUNC_IRQ);
  assign push      = push_call || push_int;
  assign pop_evt   = after_ok && sp_rose && is_ret;
  assign full      = (count_q == CntW'(STACK_DEPTH));

  // Frame to push
  always_comb begin
    if (push_int) begin
      wr_frame.caller = evt_pc_q;
      wr_frame.target = evt_irq_q;
      wr_frame.kind   = zcst_pkg::KIND_INT;
    end else if (is_call) begin
      wr_frame.caller = lat_pc_q;
      wr_frame.target = {lat_b3_q, lat_b2_q};
      wr_frame.kind   = zcst_pkg::KIND_CALL;
    end else begin
      wr_frame.caller = lat_pc_q;
      wr_frame.target = {8'h00, lat_b1_q & zcst_pkg::OP_RST_VEC};
      wr_frame.kind   = zcst_pkg::KIND_RST;
    end
    wr_frame.sp = evt_sp_q;
  end

  // Ring indices; sums stay below twice the depth
  always_comb begin
    sum_wr  = SumW'(oldest_q) + SumW'(count_q);
    sum_top = sum_wr - SumW'(1);
    if (sum_wr >= SumW'(STACK_DEPTH)) begin
      sum_wr = sum_wr - SumW'(STACK_DEPTH);
    end
    if (sum_top >= SumW'(STACK_DEPTH)) begin
      sum_top = sum_top - SumW'(STACK_DEPTH);
    end
    // on a full stack the new frame overwrites the oldest slot
    wr_idx     = full ? oldest_q : sum_wr[IdxW-1:0];
    top_idx    = sum_top[IdxW-1:0];
    oldest_inc = (oldest_q == IdxW'(STACK_DEPTH - 1)) ? '0 : oldest_q + IdxW'(1);
  end

  // Frame store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push) begin
      frame_mem[wr_idx] <= wr_frame;
    end
    if (cmd_i.rd_top) begin
      rd_frame_q <= frame_mem[top_idx];
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trace_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      trace_en_q <= cfg_trace_enable_i;
    end
  end

  // Latch, stack pointers and action
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_pc_q  <= '0;
      lat_sp_q  <= '0;
      lat_b1_q  <= '0;
      lat_b2_q  <= '0;
      lat_b3_q  <= '0;
      lat_vld_q <= 1'b0;
      oldest_q  <= '0;
      count_q   <= '0;
      act_q     <= zcst_pkg::ACT_NONE;
    end else if (cmd_i.exec) begin
      act_q <= zcst_pkg::ACT_NONE;
      if (trace_en_q && (evt_func_q == zcst_pkg::FUNC_BEFORE)) begin
        lat_pc_q  <= evt_pc_q;
        lat_sp_q  <= evt_sp_q;
        lat_b1_q  <= evt_b1_q;
        lat_b2_q  <= evt_b2_q;
        lat_b3_q  <= evt_b3_q;
        lat_vld_q <= 1'b1;
      end else if (after_ok) begin
        lat_vld_q <= 1'b0;
      end
      if (push) begin
        if (full) begin
          oldest_q <= oldest_inc;
          act_q    <= zcst_pkg::ACT_PUSH_DROP;
        end else begin
          count_q <= count_q + CntW'(1);
          act_q   <= zcst_pkg::ACT_PUSH;
        end
      end
    end else if (cmd_i.pop_one) begin
      count_q <= count_q - CntW'(1);
      act_q   <= zcst_pkg::ACT_POP;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output register payload; empty stack reports zeros
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      action_o      <= act_q;
      stack_depth_o <= count_q;
      if (count_q == '0) begin
        top_caller_o <= '0;
        top_target_o <= '0;
        top_sp_o     <= '0;
        top_kind_o   <= '0;
      end else begin
        top_caller_o <= rd_frame_q.caller;
        top_target_o <= rd_frame_q.target;
        top_sp_o     <= rd_frame_q.sp;
        top_kind_o   <= rd_frame_q.kind;
      end
    end
  end

  assign out_valid_o = out_vld_q;

  // Status to the controller
  assign st_o.pop_evt  = pop_evt;
  assign st_o.pop_hit  = (count_q != '0) && (rd_frame_q.sp <= evt_sp_q);
  assign st_o.out_busy = out_vld_q && !out_ready_i;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("frame count beyond stack depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_one |-> (count_q != '0))
    else $error("pop on empty stack");

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && push) |=> (count_q != '0))
    else $error("stack empty after push");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_vld_q && !out_ready_i))
    else $error("result register overwritten while held");
`endif

endmodule

`default_nettype wire

### rtl/core/z80_call_stack_tracker.sv
`default_nettype none

// Z80 call stack tracker for a debugger.
// Input channel (in_valid_i / in_ready_o): one event word per instruction
// phase: before execute latches pc, sp and opcode bytes; after execute
// pushes a CALL/RST frame or pops frames on a return; interrupt pushes an
// INT frame. Every event yields exactly one result word on the output
// channel (out_valid_o / out_ready_i): action, depth and the newest frame.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes trace_enable;
// it is always ready. With tracing off, events report the stack unchanged.
// Each event is captured, then executed; the newest frame is then read
// through the registered read port. A return whose sp rose by 2 instead
// reads and checks the top frame once per frame popped and once more at
// the end. The result is then loaded into the output register.
// One event is in work at a time; the next is accepted once
// the previous has been written to the output register, even while it waits.
// When the receiver stalls, the result holds and the following event
// stalls in its final cycle until the output register frees up.
// Reset empties the stack, clears the latch and disables tracing.
// The frame store needs no clearing pass; only written frames are read.
module z80_call_stack_tracker #(
  parameter int unsigned STACK_DEPTH = 64,
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1)
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire               cfg_trace_enable_i,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  [1:0]        func_i,
  input  wire  [15:0]       pc_value_i,
  input  wire  [15:0]       sp_value_i,
  input  wire  [7:0]        opcode_byte_i,
  input  wire  [7:0]        second_byte_i,
  input  wire  [7:0]        third_byte_i,
  input  wire  [15:0]       irq_target_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [1:0]        action_o,
  output logic [CntW-1:0]   stack_depth_o,
  output logic [15:0]       top_caller_o,
  output logic [15:0]       top_target_o,
  output logic [15:0]       top_sp_o,
  output logic [1:0]        top_kind_o
);

  zcst_pkg::ctrl_cmd_t  cmd;
  zcst_pkg::dp_status_t st;

  assign cfg_ready_o = 1'b1;

  zcst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  zcst_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_trace_enable_i (cfg_trace_enable_i),
    .func_i             (func_i),
    .pc_value_i         (pc_value_i),
    .sp_value_i         (sp_value_i),
    .opcode_byte_i      (opcode_byte_i),
    .second_byte_i      (second_byte_i),
    .third_byte_i       (third_byte_i),
    .irq_target_i       (irq_target_i),
    .cmd_i              (cmd),
    .st_o               (st),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .action_o           (action_o),
    .stack_depth_o      (stack_depth_o),
    .top_caller_o       (top_caller_o),
    .top_target_o       (top_target_o),
    .top_sp_o           (top_sp_o),
    .top_kind_o         (top_kind_o)
  );

endmodule

`default_nettype wire

### bench/z80_call_stack_checker.sv
`timescale 1ns / 100ps

// Watches the event, result and trace-enable channels of the call stack
// tracker, keeps its own copy of the frame stack and checks every result word.
module z80_call_stack_checker #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned CntW        = $clog2(STACK_DEPTH + 1)
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_valid_i,
  input  wire              cfg_ready_i,
  input  wire              cfg_trace_enable_i,
  input  wire              in_valid_i,
  input  wire              in_ready_i,
  input  wire  [1:0]       func_i,
  input  wire  [15:0]      pc_value_i,
  input  wire  [15:0]      sp_value_i,
  input  wire  [7:0]       opcode_byte_i,
  input  wire  [7:0]       second_byte_i,
  input  wire  [7:0]       third_byte_i,
  input  wire  [15:0]      irq_target_i,
  input  wire              out_valid_i,
  input  wire              out_ready_i,
  input  wire  [1:0]       action_i,
  input  wire  [CntW-1:0]  stack_depth_i,
  input  wire  [15:0]      top_caller_i,
  input  wire  [15:0]      top_target_i,
  input  wire  [15:0]      top_sp_i,
  input  wire  [1:0]       top_kind_i,
  output int unsigned      pending_o,
  output int unsigned      errors_o
);

  // What one result word should carry
  typedef struct packed {
    logic [1:0]       action;
    logic [CntW-1:0]  depth;
    zcst_pkg::frame_t top;
  } stack_view_t;

  // Shadow stack: a ring of frames, oldest at oldest_ix
  zcst_pkg::frame_t frames [STACK_DEPTH];
  int unsigned   oldest_ix;
  int unsigned   depth;
  logic [15:0]   lat_pc;
  logic [15:0]   lat_sp;
  logic [7:0]    lat_op;
  logic [7:0]    lat_b2;
  logic [7:0]    lat_b3;
  bit            lat_valid;
  bit            trace_on;
  stack_view_t   expected_q [$];
  int unsigned   errors = 0;

  assign errors_o = errors;

  function automatic int unsigned top_slot();
    return (oldest_ix + depth - 1) % STACK_DEPTH;
  endfunction

  // Full stack: the oldest frame goes first
  function automatic logic [1:0] add_frame(input logic [15:0] caller,
                                           input logic [15:0] target,
                                           input logic [15:0] sp,
                                           input logic [1:0] kind);
    logic [1:0]  act;
    int unsigned slot;
    act = zcst_pkg::ACT_PUSH;
    if (depth >= STACK_DEPTH) begin
      oldest_ix = (oldest_ix + 1) % STACK_DEPTH;
      depth     = STACK_DEPTH - 1;
      act       = zcst_pkg::ACT_PUSH_DROP;
    end
    slot = (oldest_ix + depth) % STACK_DEPTH;
    frames[slot].caller = caller;
    frames[slot].target = target;
    frames[slot].sp     = sp;
    frames[slot].kind   = kind;
    depth++;
    return act;
  endfunction

  // Unwind every newest frame saved at or below the new sp
  function automatic logic [1:0] pop_down_to(input logic [15:0] sp);
    logic [1:0] act;
    act = zcst_pkg::ACT_NONE;
    while (depth > 0 && frames[top_slot()].sp <= sp) begin
      depth--;
      act = zcst_pkg::ACT_POP;
    end
    return act;
  endfunction

  // Second half of an instruction: compare sp with the latched one, no wrap
  function automatic logic [1:0] retire_instr(input logic [15:0] new_sp);
    logic [16:0] old_sp;
    logic [16:0] nsp;
    logic [7:0]  masked;
    logic        is_ret;
    old_sp = {1'b0, lat_sp};
    nsp    = {1'b0, new_sp};
    masked = lat_op & zcst_pkg::OP_CC_MASK;
    is_ret = lat_op == zcst_pkg::OP_RET || masked == zcst_pkg::OP_RET_CC ||
             (lat_op == zcst_pkg::OP_ED_PREFIX &&
              (lat_b2 == zcst_pkg::OP_RETI_SFX || lat_b2 == zcst_pkg::OP_RETN_SFX));
    if (old_sp >= zcst_pkg::SP_STEP && nsp == old_sp - zcst_pkg::SP_STEP) begin
      if (lat_op == zcst_pkg::OP_CALL || masked == zcst_pkg::OP_CALL_CC)
        return add_frame(lat_pc, {lat_b3, lat_b2}, new_sp, zcst_pkg::KIND_CALL);
      if (masked == zcst_pkg::OP_RST)
        return add_frame(lat_pc, {8'h00, lat_op & zcst_pkg::OP_RST_VEC}, new_sp,
                         zcst_pkg::KIND_RST);
    end
    if (nsp == old_sp + zcst_pkg::SP_STEP && is_ret)
      return pop_down_to(new_sp);
    return zcst_pkg::ACT_NONE;
  endfunction

  function automatic stack_view_t apply_event(input logic [1:0] func,
                                              input logic [15:0] pc,
                                              input logic [15:0] sp,
                                              input logic [7:0] op,
                                              input logic [7:0] b2,
                                              input logic [7:0] b3,
                                              input logic [15:0] irq);
    stack_view_t view;
    view.action = zcst_pkg::ACT_NONE;
    if (trace_on) begin
      case (func)
        zcst_pkg::FUNC_BEFORE: begin
          lat_pc    = pc;
          lat_sp    = sp;
          lat_op    = op;
          lat_b2    = b2;
          lat_b3    = b3;
          lat_valid = 1'b1;
        end
        zcst_pkg::FUNC_AFTER: begin
          if (lat_valid) begin
            lat_valid   = 1'b0;
            view.action = retire_instr(sp);
          end
        end
        zcst_pkg::FUNC_IRQ: begin
          view.action = add_frame(pc, irq, sp, zcst_pkg::KIND_INT);
        end
        default: begin
        end
      endcase
    end
    view.depth = CntW'(depth);
    if (depth > 0)
      view.top = frames[top_slot()];
    else
      view.top = '0;
    return view;
  endfunction

  task automatic note_field(input string field, input logic [15:0] want,
                            input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  task automatic check_result();
    stack_view_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: result word with none outstanding, expected none,",
               $time, " actual action %h depth %h", action_i, stack_depth_i);
    end else begin
      want = expected_q.pop_front();
      note_field("action", 16'(want.action), 16'(action_i));
      note_field("stack_depth", 16'(want.depth), 16'(stack_depth_i));
      note_field("top_caller", want.top.caller, top_caller_i);
      note_field("top_target", want.top.target, top_target_i);
      note_field("top_sp", want.top.sp, top_sp_i);
      note_field("top_kind", 16'(want.top.kind), 16'(top_kind_i));
    end
  endtask

  // Sample all three channels at each rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      oldest_ix = 0;
      depth     = 0;
      lat_pc    = '0;
      lat_sp    = '0;
      lat_op    = '0;
      lat_b2    = '0;
      lat_b3    = '0;
      lat_valid = 1'b0;
      trace_on  = 1'b0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i)
        trace_on = cfg_trace_enable_i;
      if (out_valid_i && out_ready_i)
        check_result();
      if (in_valid_i && in_ready_i)
        expected_q.insert(expected_q.size(),
                          apply_event(func_i, pc_value_i, sp_value_i, opcode_byte_i,
                                      second_byte_i, third_byte_i, irq_target_i));
      pending_o <= expected_q.size();
    end
  end

endmodule

### bench/tb_z80_call_stack_tracker.sv
`timescale 1ns / 100ps

// Drives event words into the call stack tracker with random gaps and
// receiver stalls; the checker beside the block judges every result word.
module tb_z80_call_stack_tracker;

  localparam int unsigned STACK_DEPTH    = 64;
  localparam int unsigned CntW           = $clog2(STACK_DEPTH + 1);
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_trace_enable_i = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        func_i = '0;
  logic [15:0]       pc_value_i = '0;
  logic [15:0]       sp_value_i = '0;
  logic [7:0]        opcode_byte_i = '0;
  logic [7:0]        second_byte_i = '0;
  logic [7:0]        third_byte_i = '0;
  logic [15:0]       irq_target_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        action_o;
  logic [CntW-1:0]   stack_depth_o;
  logic [15:0]       top_caller_o;
  logic [15:0]       top_target_o;
  logic [15:0]       top_sp_o;
  logic [1:0]        top_kind_o;

  int unsigned       result_backlog;
  int unsigned       err_total;
  int unsigned       words_sent = 0;
  int unsigned       stall_left = 0;
  int unsigned       stuck_cycles = 0;
  int unsigned       call_pct;
  int unsigned       ph;
  bit                quiet = 1'b0;
  logic [15:0]       cpu_sp = 16'h8000;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  z80_call_stack_tracker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_trace_enable_i(cfg_trace_enable_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .pc_value_i        (pc_value_i),
    .sp_value_i        (sp_value_i),
    .opcode_byte_i     (opcode_byte_i),
    .second_byte_i     (second_byte_i),
    .third_byte_i      (third_byte_i),
    .irq_target_i      (irq_target_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .action_o          (action_o),
    .stack_depth_o     (stack_depth_o),
    .top_caller_o      (top_caller_o),
    .top_target_o      (top_target_o),
    .top_sp_o          (top_sp_o),
    .top_kind_o        (top_kind_o)
  );

  z80_call_stack_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_trace_enable_i(cfg_trace_enable_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .func_i            (func_i),
    .pc_value_i        (pc_value_i),
    .sp_value_i        (sp_value_i),
    .opcode_byte_i     (opcode_byte_i),
    .second_byte_i     (second_byte_i),
    .third_byte_i      (third_byte_i),
    .irq_target_i      (irq_target_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .action_i          (action_o),
    .stack_depth_i     (stack_depth_o),
    .top_caller_i      (top_caller_o),
    .top_target_i      (top_target_o),
    .top_sp_i          (top_sp_o),
    .top_kind_i        (top_kind_o),
    .pending_o         (result_backlog),
    .errors_o          (err_total)
  );

  // Mostly short gaps, now and then a long one; none in quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stalls on the result channel
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 9) < 3)
        stall_left <= pick_gap();
    end
  end

  // Watchdog: cycles in which no word moves on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles == WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Present one event word and hold it until taken
  task automatic send_event(input logic [1:0] func, input logic [15:0] pc,
                            input logic [15:0] sp, input logic [7:0] op,
                            input logic [7:0] b2, input logic [7:0] b3,
                            input logic [15:0] irq);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    func_i        <= func;
    pc_value_i    <= pc;
    sp_value_i    <= sp;
    opcode_byte_i <= op;
    second_byte_i <= b2;
    third_byte_i  <= b3;
    irq_target_i  <= irq;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // Before and after events of one instruction; unused fields random
  task automatic run_instr(input logic [15:0] pc, input logic [15:0] sp,
                           input logic [7:0] op, input logic [7:0] b2,
                           input logic [7:0] b3, input logic [15:0] sp_after);
    send_event(zcst_pkg::FUNC_BEFORE, pc, sp, op, b2, b3, 16'($urandom));
    send_event(zcst_pkg::FUNC_AFTER, 16'($urandom), sp_after, 8'($urandom),
               8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // Stop sending and wait for every outstanding result word
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (result_backlog != 0);
  endtask

  task automatic write_trace(input logic enable);
    drain_results();
    cfg_trace_enable_i <= enable;
    cfg_valid_i        <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Program-like traffic: calls, interrupts, returns, plain instructions,
  // sp reloads and raw noise, weighted by call_bias
  task automatic run_program(input int unsigned n_words, input int unsigned call_bias);
    int unsigned stop_at;
    int unsigned r;
    logic [7:0]  op;
    logic [7:0]  b2;
    logic [15:0] new_sp;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 49) == 0)
        quiet = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < call_bias) begin
        case ($urandom_range(0, 2))
          0: op = zcst_pkg::OP_CALL;
          1: op = zcst_pkg::OP_CALL_CC | (8'($urandom_range(0, 7)) << 3);
          default: op = zcst_pkg::OP_RST | (8'($urandom_range(0, 7)) << 3);
        endcase
        run_instr(16'($urandom), cpu_sp, op, 8'($urandom), 8'($urandom), cpu_sp - 16'd2);
        cpu_sp -= 16'd2;
      end else if (r < call_bias + 8) begin
        cpu_sp -= 16'd2;
        send_event(zcst_pkg::FUNC_IRQ, 16'($urandom), cpu_sp, 8'($urandom),
                   8'($urandom), 8'($urandom), 16'($urandom));
      end else if (r < call_bias + 30) begin
        b2 = 8'($urandom);
        case ($urandom_range(0, 3))
          0: op = zcst_pkg::OP_RET;
          1: op = zcst_pkg::OP_RET_CC | (8'($urandom_range(0, 7)) << 3);
          default: begin
            op = zcst_pkg::OP_ED_PREFIX;
            b2 = $urandom_range(0, 1) ? zcst_pkg::OP_RETI_SFX : zcst_pkg::OP_RETN_SFX;
          end
        endcase
        // sometimes sp was moved up first, so one return unwinds several frames
        if ($urandom_range(0, 3) == 0)
          cpu_sp += 16'(2 * $urandom_range(1, 8));
        run_instr(16'($urandom), cpu_sp, op, b2, 8'($urandom), cpu_sp + 16'd2);
        cpu_sp += 16'd2;
      end else if (r < call_bias + 40) begin
        new_sp = cpu_sp + 16'($urandom_range(0, 4)) - 16'd2;
        run_instr(16'($urandom), cpu_sp, 8'($urandom), 8'($urandom), 8'($urandom), new_sp);
        cpu_sp = new_sp;
      end else if (r < call_bias + 44) begin
        case ($urandom_range(0, 5))
          0: cpu_sp = 16'h0000;
          1: cpu_sp = 16'h0001;
          2: cpu_sp = 16'h0002;
          3: cpu_sp = 16'hFFFD;
          4: cpu_sp = 16'hFFFF;
          default: cpu_sp = 16'($urandom_range(16'h0100, 16'hFFF0));
        endcase
      end else begin
        send_event(2'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: build a few frames, unwind them, then the sp range ends
    write_trace(1'b1);
    send_event(zcst_pkg::FUNC_AFTER, 16'h0000, 16'h1234, 8'h00, 8'h00, 8'h00, 16'h0000);
    run_instr(16'h1000, 16'h8000, zcst_pkg::OP_CALL, 8'h34, 8'h12, 16'h7FFE);
    run_instr(16'hFFFF, 16'h7FFE, zcst_pkg::OP_CALL_CC | 8'h38, 8'hFF, 8'hFF, 16'h7FFC);
    run_instr(16'h2000, 16'h7FFC, zcst_pkg::OP_RST | zcst_pkg::OP_RST_VEC,
              8'h00, 8'h00, 16'h7FFA);
    send_event(zcst_pkg::FUNC_IRQ, 16'hFFFF, 16'h7FF8, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    // unused event kind
    send_event(zcst_pkg::FUNC_RSVD, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    run_instr(16'h0038, 16'h7FF8, zcst_pkg::OP_ED_PREFIX, zcst_pkg::OP_RETI_SFX,
              8'h00, 16'h7FFA);
    run_instr(16'h0039, 16'h7FFA, zcst_pkg::OP_ED_PREFIX, zcst_pkg::OP_RETN_SFX,
              8'h00, 16'h7FFC);
    run_instr(16'h1234, 16'h7FFC, zcst_pkg::OP_RET_CC, 8'h00, 8'h00, 16'h7FFE);
    // return with the stack already empty
    run_instr(16'h1235, 16'h7FFE, zcst_pkg::OP_RET, 8'h00, 8'h00, 16'h8000);
    // sp at the ends of its range never wraps
    run_instr(16'h0100, 16'h0001, zcst_pkg::OP_CALL, 8'h00, 8'h01, 16'hFFFF);
    run_instr(16'h0101, 16'hFFFE, zcst_pkg::OP_RET, 8'h00, 8'h00, 16'h0000);
    run_instr(16'h0102, 16'h0002, zcst_pkg::OP_CALL, 8'hAA, 8'h55, 16'h0000);
    run_instr(16'h0103, 16'hFFFD, zcst_pkg::OP_RET, 8'h00, 8'h00, 16'hFFFF);

    // Random phases; the tracing-off one is short since it is ignored
    for (ph = 0; ph < 6; ph++) begin
      write_trace(ph != 2);
      call_pct = (ph == 3 || ph == 5) ? 75 : $urandom_range(30, 55);
      run_program((ph == 2) ? 60 : 300, call_pct);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (err_total == 0 && result_backlog == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
